// ----- rtl/core/tnrbc_pkg.sv -----
// Shared types and constants of the triangle near reject and backface cull stage.
package tnrbc_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 23;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TRI  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIREFRAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_W    = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [23:0]      world_x;
        logic signed [23:0]      world_y;
        logic signed [23:0]      world_z;
        logic signed [23:0]      proj_w;
        logic [IDX_W-1:0]        corner0;
        logic [IDX_W-1:0]        corner1;
        logic [IDX_W-1:0]        corner2;
        logic [15:0]             tex0;
        logic [15:0]             tex1;
        logic [15:0]             tex2;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]        out_corner0;
        logic [IDX_W-1:0]        out_corner1;
        logic [IDX_W-1:0]        out_corner2;
        logic [15:0]             out_tex0;
        logic [15:0]             out_tex1;
        logic [15:0]             out_tex2;
        logic signed [15:0]      normal_x;
        logic signed [15:0]      normal_y;
        logic signed [15:0]      normal_z;
    } t_out;

    typedef struct packed {
        logic signed [23:0]      x;
        logic signed [23:0]      y;
        logic signed [23:0]      z;
        logic signed [23:0]      w;
    } t_vtx;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_CROSS = 9'b000000100,
        S_DOT   = 9'b000001000,
        S_NORM  = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_SQRT  = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

endpackage

// ----- rtl/core/triangle_near_reject_backface_cull.sv -----
// Triangle setup stage: vertex store, near-plane reject, backface cull, unit normal.
//
// Input channel (i_valid / o_stall / i_data) carries two kinds of transfer. A load
// transfer writes one vertex (world x, y, z, projected w) into the store.
// A triangle transfer reads its three corners, one per cycle, and drops the triangle
// when any projected w is at or below the near threshold. Otherwise one 32x32
// multiplier forms the cross product and, unless wireframe mode is set, the sign
// test against the first corner; back faces are dropped. Kept triangles leave on the
// output channel (o_valid / i_stall / o_data) with indices and a Q1.14 unit normal.
// The unit normal comes from a normalizing shift of one bit per cycle, a 32-step
// square root and three divisions; in wireframe mode a zero normal skips them and
// is emitted as zero. o_stall stays high while a triangle is in work. A finished
// result waits in the output register; new transfers are taken meanwhile, and the
// block holds only when a second result is ready before the receiver drops i_stall.
// Reset clears control and the config registers (wireframe off, threshold 1); the
// vertex store is undefined until loaded. Write config only while the block is idle.
module triangle_near_reject_backface_cull (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  tnrbc_pkg::t_in                      i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output tnrbc_pkg::t_out                     o_data,
    input  logic                                i_cfg_we,
    input  logic [tnrbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tnrbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tnrbc_pkg::*;

    // vertex store: one row holds all four coordinates
    t_vtx               mem [VERTEX_COUNT];
    t_vtx               r_rd;
    logic [IDX_W-1:0]   rd_addr;

    t_state             r_state;
    logic [2:0]         r_step;
    t_in                r_item;
    t_vtx               r_v [3];
    logic               r_rej;
    logic               r_wire;
    logic [22:0]        r_thr;

    logic signed [49:0] r_n [3];
    logic signed [75:0] r_acc;
    logic [49:0]        r_mag [3];
    logic [2:0]         r_neg;
    logic [63:0]        r_l2;
    logic [63:0]        r_x;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [46:0]        r_rem;
    logic [14:0]        r_q;
    logic [3:0]         r_k;
    logic signed [15:0] r_nrm [3];
    logic signed [63:0] r_prod;

    t_out               r_out;
    logic               r_out_valid;

    logic               in_xfer;
    logic               out_xfer;
    logic               out_load;
    logic signed [24:0] e1 [3];
    logic signed [24:0] e2 [3];
    logic signed [23:0] w0 [3];
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic [2:0]         jc;
    logic [1:0]         acc_comp;
    logic signed [75:0] p76;
    logic signed [75:0] acc_next;
    logic [49:0]        m_max;
    logic [63:0]        sq_trial;
    logic [31:0]        len;
    logic [46:0]        div_num;
    logic [46:0]        div_d;
    logic               div_ge;
    logic [14:0]        q_next;
    logic [15:0]        q_res;
    logic               rej_now;

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // edges relative to the first corner
    always_comb begin
        w0[0] = r_v[0].x;
        w0[1] = r_v[0].y;
        w0[2] = r_v[0].z;
        e1[0] = 25'(r_v[1].x) - 25'(r_v[0].x);
        e1[1] = 25'(r_v[1].y) - 25'(r_v[0].y);
        e1[2] = 25'(r_v[1].z) - 25'(r_v[0].z);
        e2[0] = 25'(r_v[2].x) - 25'(r_v[0].x);
        e2[1] = 25'(r_v[2].y) - 25'(r_v[0].y);
        e2[2] = 25'(r_v[2].z) - 25'(r_v[0].z);
    end

    always_comb begin
        case (r_step)
            3'd0:    rd_addr = r_item.corner0;
            3'd1:    rd_addr = r_item.corner1;
            default: rd_addr = r_item.corner2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_data.op == OP_LOAD) begin
            mem[i_data.vertex_index] <= '{x: i_data.world_x, y: i_data.world_y,
                                          z: i_data.world_z, w: i_data.proj_w};
        end
        r_rd <= mem[rd_addr];
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CROSS: begin
                case (r_step)
                    3'd0: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[2]); end
                    3'd1: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[1]); end
                    3'd2: begin mul_a = 32'(e1[2]); mul_b = 32'(e2[0]); end
                    3'd3: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[2]); end
                    3'd4: begin mul_a = 32'(e1[0]); mul_b = 32'(e2[1]); end
                    3'd5: begin mul_a = 32'(e1[1]); mul_b = 32'(e2[0]); end
                    default: ;
                endcase
            end
            S_DOT: begin
                if (r_step < 3'd6) begin
                    if (r_step[0]) begin
                        mul_a = 32'($signed(r_n[r_step[2:1]][49:26]));
                    end else begin
                        mul_a = $signed({6'b0, r_n[r_step[2:1]][25:0]});
                    end
                    mul_b = 32'(w0[r_step[2:1]]);
                end
            end
            S_SQ: begin
                if (r_step < 3'd3) begin
                    mul_a = $signed({2'b0, r_mag[r_step[1:0]][29:0]});
                    mul_b = $signed({2'b0, r_mag[r_step[1:0]][29:0]});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        jc       = r_step - 3'd1;
        acc_comp = jc[2:1];
        p76      = 76'(r_prod);
        acc_next = r_acc + (r_step[0] ? p76 : (p76 <<< 26));
        m_max    = r_mag[0];
        if (r_mag[1] > m_max) m_max = r_mag[1];
        if (r_mag[2] > m_max) m_max = r_mag[2];
        sq_trial = r_res + r_bit;
        len      = r_res[31:0];
        div_num  = 47'({r_mag[r_step[1:0]][29:0], 15'b0}) + 47'(len);
        div_d    = 47'({len, 1'b0}) << r_k;
        div_ge   = (r_rem >= div_d);
        q_next   = {r_q[13:0], div_ge};
        q_res    = r_neg[r_step[1:0]] ? 16'(-{1'b0, q_next}) : {1'b0, q_next};
        rej_now  = (r_rd.w <= $signed({1'b0, r_thr}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_wire      <= 1'b0;
            r_thr       <= 23'd1;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIREFRAME: r_wire <= i_cfg_data[0];
                    CFG_NEAR_W:    r_thr  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load)      r_out_valid <= 1'b1;
            else if (out_xfer) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_data.op == OP_TRI) begin
                        r_item  <= i_data;
                        r_step  <= '0;
                        r_rej   <= 1'b0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // address goes out on step 0..2, registered data is stored on step 1..3
                    if (r_step != 3'd0) begin
                        r_v[jc[1:0]] <= r_rd;
                        if (rej_now) r_rej <= 1'b1;
                    end
                    if (r_step == 3'd3) begin
                        r_step  <= '0;
                        r_state <= (r_rej || rej_now) ? S_IDLE : S_CROSS;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_CROSS: begin
                    if (r_step != 3'd0) begin
                        if (r_step[0]) r_n[acc_comp] <= r_prod[49:0];
                        else           r_n[acc_comp] <= r_n[acc_comp] - r_prod[49:0];
                    end
                    if (r_step == 3'd6) begin
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_state <= r_wire ? S_NORM : S_DOT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_DOT: begin
                    if (r_step != 3'd0) r_acc <= acc_next;
                    if (r_step == 3'd6) begin
                        // drop back faces: normal pointing away from the eye
                        r_step  <= '0;
                        r_state <= acc_next[75] ? S_NORM : S_IDLE;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_NORM: begin
                    if (r_step == 3'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_n[i][49] ? 50'(-r_n[i]) : r_n[i];
                            r_neg[i] <= r_n[i][49];
                        end
                        r_step <= 3'd1;
                    end else if (m_max == '0) begin
                        for (int i = 0; i < 3; i++) r_nrm[i] <= '0;
                        r_state <= S_DONE;
                    end else if (m_max[49:29] == '0) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else if (m_max[49:30] != '0) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_l2    <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_step != 3'd0) r_l2 <= r_l2 + $unsigned(r_prod);
                    if (r_step == 3'd3) begin
                        r_x     <= r_l2 + $unsigned(r_prod);
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
                S_SQRT: begin
                    if (r_x >= sq_trial) begin
                        r_x   <= r_x - sq_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_step  <= '0;
                        r_k     <= 4'd15;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // round half away: (2*r*16384 + L) / (2*L)
                    if (r_k == 4'd15) begin
                        r_rem <= div_num;
                        r_q   <= '0;
                        r_k   <= 4'd14;
                    end else begin
                        if (div_ge) r_rem <= r_rem - div_d;
                        r_q <= q_next;
                        if (r_k == 4'd0) begin
                            r_nrm[r_step[1:0]] <= q_res;
                            r_k <= 4'd15;
                            if (r_step == 3'd2) r_state <= S_DONE;
                            else                r_step  <= r_step + 3'd1;
                        end else begin
                            r_k <= r_k - 4'd1;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_out <= '{out_corner0: r_item.corner0,
                                   out_corner1: r_item.corner1,
                                   out_corner2: r_item.corner2,
                                   out_tex0:    r_item.tex0,
                                   out_tex1:    r_item.tex1,
                                   out_tex2:    r_item.tex2,
                                   normal_x:    r_nrm[0],
                                   normal_y:    r_nrm[1],
                                   normal_z:    r_nrm[2]};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
